>>> sv/cr_terminated_command_assembler_defines.svh
// Assertion macros for the command assembler
`ifndef CR_TERMINATED_COMMAND_ASSEMBLER_DEFINES_SVH
`define CR_TERMINATED_COMMAND_ASSEMBLER_DEFINES_SVH

// Combinational invariant, checked every cycle out of reset
`define CRTA_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("crta invariant violated");

// Implication on the same cycle
`define CRTA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crta implication violated");

// Implication into the next cycle
`define CRTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crta next-cycle implication violated");

`endif

>>> sv/crta_pkg.sv
// Shared types and constants for the command assembler
`timescale 1ns / 1ps
package crta_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned LEN_W          = 7;
  localparam int unsigned LINE_DEPTH_DEF = 64;

  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  // Per-cell control: load from the input byte, or take the neighbor's byte
  typedef struct packed {
    logic wr_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

>>> sv/crta_cell.sv
// One byte cell of the line store chain
`timescale 1ns / 1ps
module crta_cell (
  input  logic                       clk_i,
  input  crta_pkg::cell_ctrl_t       ctrl_i,
  input  logic [crta_pkg::BYTE_W-1:0] wr_data_i,
  input  logic [crta_pkg::BYTE_W-1:0] next_i,
  output logic [crta_pkg::BYTE_W-1:0] data_o
);
  import crta_pkg::*;

  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] data_d;

  always_comb begin
    priority if (ctrl_i.wr_en) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift_en) begin
      data_d = next_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> sv/cr_terminated_command_assembler.sv
// Top level: CR-terminated command assembler over a chain of byte cells
// An overflow result is valid in the cycle after its accepting edge. A CR that flushes a
// command sets the emit state, from which the first byte goes to the result register, then one
// byte per cycle while not stalled. Throughput: one input byte per cycle while the result
// register is free; no byte is taken during a flush.
// Reset clears fill count, flush state, output valid and sets forward_enable; cells keep data.
`timescale 1ns / 1ps
`include "cr_terminated_command_assembler_defines.svh"
module cr_terminated_command_assembler #(
  parameter int unsigned LINE_DEPTH = crta_pkg::LINE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [crta_pkg::BYTE_W-1:0] rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [crta_pkg::BYTE_W-1:0] cmd_byte_o,
  output logic [crta_pkg::LEN_W-1:0]  cmd_length_o,
  output logic                        last_o,
  output logic                        overflow_o
);
  import crta_pkg::*;

  localparam int unsigned FW = $clog2(LINE_DEPTH + 1);

  state_e            state_q, state_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [FW-1:0]     rem_q, rem_d;
  logic [FW-1:0]     len_q, len_d;
  logic              fwd_q;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;

  logic              out_free;
  logic              in_acc;
  logic              is_full;
  logic              append;
  logic              shift;
  logic              last_beat;

  logic [BYTE_W-1:0] cell_data [LINE_DEPTH];
  logic [BYTE_W-1:0] cell_next [LINE_DEPTH];
  cell_ctrl_t        cell_ctrl [LINE_DEPTH];

  // Cell chain: cell k takes cell k+1 on a shift; the head feeds the output
  for (genvar k = 0; k < LINE_DEPTH; k++) begin : g_cell
    if (k == LINE_DEPTH - 1) begin : g_tail
      assign cell_next[k] = cell_data[k];
    end else begin : g_body
      assign cell_next[k] = cell_data[k+1];
    end
    assign cell_ctrl[k].wr_en    = append && (fill_q == FW'(k));
    assign cell_ctrl[k].shift_en = shift;

    crta_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl[k]),
      .wr_data_i (rx_byte_i),
      .next_i    (cell_next[k]),
      .data_o    (cell_data[k])
    );
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_full    = (fill_q >= FW'(LINE_DEPTH));
  assign last_beat  = (rem_q == FW'(1));

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    append      = 1'b0;
    shift       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (is_full) begin
            fill_d      = '0;
            out_valid_d = 1'b1;
            out_byte_d  = '0;
            out_len_d   = '0;
            out_last_d  = 1'b1;
            out_ovf_d   = 1'b1;
          end else if (rx_byte_i == CHAR_LF || rx_byte_i == CHAR_NUL) begin
            fill_d = fill_q;
          end else if (rx_byte_i != CHAR_CR) begin
            append = 1'b1;
            fill_d = fill_q + FW'(1);
          end else begin
            fill_d = '0;
            if (fill_q != '0 && fwd_q) begin
              rem_d   = fill_q;
              len_d   = fill_q;
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          shift       = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = cell_data[0];
          out_len_d   = LEN_W'(len_q);
          out_last_d  = last_beat;
          out_ovf_d   = 1'b0;
          rem_d       = rem_q - FW'(1);
          if (last_beat) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rem_q       <= '0;
      fwd_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fwd_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    out_byte_q <= out_byte_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_byte_o   = out_byte_q;
  assign cmd_length_o = out_len_q;
  assign last_o       = out_last_q;
  assign overflow_o   = out_ovf_q;

  `CRTA_ASSERT_ALWAYS(a_fill_bound, fill_q <= FW'(LINE_DEPTH))
  `CRTA_ASSERT_IMPL(a_emit_rem, state_q == ST_EMIT, rem_q != '0 && rem_q <= len_q)
  `CRTA_ASSERT_IMPL(a_ovf_fields, out_valid_o && overflow_o, last_o && cmd_length_o == '0)
  `CRTA_ASSERT_NEXT(a_last_ends, state_q == ST_EMIT && out_free && last_beat, !in_stall_o || last_o)

endmodule
